// ----- src/power_sum_mod_assert.svh -----
// Assertion macros shared by the power_sum_mod RTL.
// Pulled in by `include; depends on nothing else.
`ifndef POWER_SUM_MOD_ASSERT_SVH
`define POWER_SUM_MOD_ASSERT_SVH

// Same-cycle implication, reset-qualified.
`define PSM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define PSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/psm_pkg.sv -----
// Shared types, constants and microcode ROM for power_sum_mod.
// No dependencies; used by psm_modmul and power_sum_mod.
package psm_pkg;

    localparam logic [23:0] PSM_MOD     = 24'd10000007;
    localparam logic [25:0] PSM_MOD_X1  = 26'd10000007;
    localparam logic [25:0] PSM_MOD_X2  = 26'd20000014;
    localparam logic [25:0] PSM_MOD_X4  = 26'd40000028;
    // Barrett constant floor(2^48 / M), fits in 25 bits
    localparam logic [63:0] PSM_MU_FULL = (64'd1 << 48) / 64'd10000007;
    localparam logic [24:0] PSM_MU      = PSM_MU_FULL[24:0];

    typedef logic [23:0] t_res;
    typedef logic [25:0] t_sum;
    typedef logic [4:0]  t_upc;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT,
        SEQ_LOOP,
        SEQ_JUMP
    } t_seq;

    typedef enum logic [2:0] {
        OPA_N,
        OPA_M,
        OPA_SQN,
        OPA_SQM,
        OPA_ACC0,
        OPA_ACC1,
        OPA_ACC2,
        OPA_ACC3
    } t_opa;

    typedef enum logic [1:0] {
        OPB_ONE,
        OPB_SQN,
        OPB_SQM
    } t_opb;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_SQN,
        DST_SQM,
        DST_ACC0,
        DST_ACC1,
        DST_ACC2,
        DST_ACC3
    } t_dst;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_EK,
        COND_EM,
        COND_EN
    } t_cond;

    typedef enum logic [2:0] {
        POST_NONE,
        POST_LOAD,
        POST_SUM,
        POST_RED4,
        POST_RED2,
        POST_RED1
    } t_post;

    typedef struct packed {
        t_seq  seq;
        t_upc  target;
        t_opa  opa;
        t_opb  opb;
        t_dst  dst;
        t_cond cond;
        t_post post;
    } t_uword;

    // multiplier issue / writeback control
    typedef struct packed {
        logic valid;
        t_dst dst;
    } t_mm_ctl;

    // microcode addresses; unlisted addresses are pipeline-fill no-ops
    localparam t_upc UPC_IDLE   = 5'd0;
    localparam t_upc UPC_INIT_N = 5'd1;
    localparam t_upc UPC_INIT_M = 5'd2;
    localparam t_upc UPC_SQ_N   = 5'd7;
    localparam t_upc UPC_SQ_M   = 5'd8;
    localparam t_upc UPC_MUL0   = 5'd9;
    localparam t_upc UPC_MUL1   = 5'd10;
    localparam t_upc UPC_MUL2   = 5'd11;
    localparam t_upc UPC_MUL3   = 5'd12;
    localparam t_upc UPC_SUM    = 5'd18;
    localparam t_upc UPC_RED4   = 5'd19;
    localparam t_upc UPC_RED2   = 5'd20;
    localparam t_upc UPC_RED1   = 5'd21;

    function automatic t_uword psm_ucode(input t_upc pc);
        t_uword w;
        w = '{seq: SEQ_NEXT, target: UPC_IDLE, opa: OPA_N, opb: OPB_ONE,
              dst: DST_NONE, cond: COND_ALWAYS, post: POST_NONE};
        unique case (pc)
            UPC_IDLE: begin
                w.seq  = SEQ_WAIT;
                w.post = POST_LOAD;
            end
            UPC_INIT_N: begin
                w.opa = OPA_N;
                w.dst = DST_SQN;
            end
            UPC_INIT_M: begin
                w.opa = OPA_M;
                w.dst = DST_SQM;
            end
            UPC_SQ_N: begin
                w.opa = OPA_SQN;
                w.opb = OPB_SQN;
                w.dst = DST_SQN;
            end
            UPC_SQ_M: begin
                w.opa = OPA_SQM;
                w.opb = OPB_SQM;
                w.dst = DST_SQM;
            end
            UPC_MUL0: begin
                w.opa  = OPA_ACC0;
                w.opb  = OPB_SQN;
                w.dst  = DST_ACC0;
                w.cond = COND_EK;
            end
            UPC_MUL1: begin
                w.opa  = OPA_ACC1;
                w.opb  = OPB_SQM;
                w.dst  = DST_ACC1;
                w.cond = COND_EK;
            end
            UPC_MUL2: begin
                w.opa  = OPA_ACC2;
                w.opb  = OPB_SQM;
                w.dst  = DST_ACC2;
                w.cond = COND_EM;
            end
            UPC_MUL3: begin
                w.opa    = OPA_ACC3;
                w.opb    = OPB_SQN;
                w.dst    = DST_ACC3;
                w.cond   = COND_EN;
                w.seq    = SEQ_LOOP;
                w.target = UPC_SQ_N;
            end
            UPC_SUM:  w.post = POST_SUM;
            UPC_RED4: w.post = POST_RED4;
            UPC_RED2: w.post = POST_RED2;
            UPC_RED1: begin
                w.post   = POST_RED1;
                w.seq    = SEQ_JUMP;
                w.target = UPC_IDLE;
            end
            default: w.seq = SEQ_NEXT;
        endcase
        return w;
    endfunction

endpackage

// ----- src/power_sum_mod.sv -----
// Top level of power_sum_mod: microcoded sequencer, register file and sum.
// Depends on psm_pkg, psm_modmul and power_sum_mod_assert.svh.
//
// Computes (n^k + 2*(n-1)^k + 2*(n-1)^(n-1) + n^n) mod 10000007.
// Command channel: a transaction is taken at a clock edge where start is
// high and busy is low; i_base_n and i_exponent_k are sampled at that edge.
// Result channel: o_sum_mod is valid for exactly one cycle, flagged by
// o_strobe; the receiver cannot stall, so it must take it in that cycle.
// busy drops in the strobe cycle, so a new command may be accepted at
// the edge that ends it.
// The step sequence is set by the single shared modular multiplier:
// each exponent bit issues two squarings and four conditional
// multiplies, one per cycle, and the multiplier pipeline closes the loop
// exactly on the squared bases. Further steps fill and drain the
// multiplier and fold the final sum.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// the strobe; no state is kept between transactions.
module power_sum_mod #(
    parameter int EXP_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [31:0]   i_base_n,
    input  logic [31:0]   i_exponent_k,
    output psm_pkg::t_res o_sum_mod,
    output logic          o_strobe
);
    import psm_pkg::*;

    `include "power_sum_mod_assert.svh"

    localparam int              BIT_W    = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(EXP_BITS - 1);

    // sequencer
    t_upc             r_pc, n_pc;
    logic [BIT_W-1:0] r_bit, n_bit;
    t_uword           u;
    logic             accept;
    logic             last_bit;

    // register file: bases, exponent shifters, squares, accumulators
    logic [31:0] r_n, r_m;
    logic [31:0] r_ek, r_em, r_en;
    t_res        r_sqn, r_sqm;
    t_res        r_acc [4];
    t_sum        r_sum;
    t_res        r_out;
    logic        r_strobe;

    // multiplier hookup
    logic [31:0] opa;
    t_res        opb;
    logic        cond_ok;
    t_mm_ctl     iss_ctl;
    t_mm_ctl     wb_ctl;
    t_res        wb_res;

    // final fold
    t_sum red_thr;
    t_sum red_val;
    t_sum sum_all;

    assign u        = psm_ucode(r_pc);
    assign busy     = (r_pc != UPC_IDLE);
    assign accept   = start && !busy;
    assign last_bit = (r_bit == LAST_BIT);

    // next step
    always_comb begin
        n_pc  = r_pc;
        n_bit = r_bit;
        unique case (u.seq)
            SEQ_WAIT: begin
                if (accept) begin
                    n_pc  = r_pc + t_upc'(1);
                    n_bit = '0;
                end
            end
            SEQ_NEXT: n_pc = r_pc + t_upc'(1);
            SEQ_LOOP: begin
                if (last_bit) begin
                    n_pc  = r_pc + t_upc'(1);
                    n_bit = '0;
                end else begin
                    n_pc  = u.target;
                    n_bit = r_bit + BIT_W'(1);
                end
            end
            SEQ_JUMP: n_pc = u.target;
        endcase
    end

    // operand and condition selection from the control word
    always_comb begin
        unique case (u.opa)
            OPA_N:    opa = r_n;
            OPA_M:    opa = r_m;
            OPA_SQN:  opa = 32'(r_sqn);
            OPA_SQM:  opa = 32'(r_sqm);
            OPA_ACC0: opa = 32'(r_acc[0]);
            OPA_ACC1: opa = 32'(r_acc[1]);
            OPA_ACC2: opa = 32'(r_acc[2]);
            OPA_ACC3: opa = 32'(r_acc[3]);
        endcase
    end

    always_comb begin
        case (u.opb)
            OPB_SQN: opb = r_sqn;
            OPB_SQM: opb = r_sqm;
            default: opb = t_res'(1);
        endcase
    end

    always_comb begin
        unique case (u.cond)
            COND_ALWAYS: cond_ok = 1'b1;
            COND_EK:     cond_ok = r_ek[0];
            COND_EM:     cond_ok = r_em[0];
            COND_EN:     cond_ok = r_en[0];
        endcase
    end

    // a clear exponent bit simply never issues the multiply
    assign iss_ctl.valid = (u.dst != DST_NONE) && cond_ok;
    assign iss_ctl.dst   = u.dst;

    psm_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (iss_ctl),
        .i_opa   (opa),
        .i_opb   (opb),
        .o_ctl   (wb_ctl),
        .o_res   (wb_res)
    );

    // sum < 6M; fold with 4M, 2M, M in three steps
    assign sum_all = t_sum'(r_acc[0]) + t_sum'(r_acc[3])
                   + ((t_sum'(r_acc[1]) + t_sum'(r_acc[2])) << 1);

    always_comb begin
        unique case (u.post)
            POST_RED4: red_thr = PSM_MOD_X4;
            POST_RED2: red_thr = PSM_MOD_X2;
            default:   red_thr = PSM_MOD_X1;
        endcase
        red_val = (r_sum >= red_thr) ? (r_sum - red_thr) : r_sum;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= UPC_IDLE;
            r_bit    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_bit    <= n_bit;
            r_strobe <= (u.post == POST_RED1);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((u.post == POST_LOAD) && accept) begin
            r_n  <= i_base_n;
            r_m  <= i_base_n - 32'd1;
            r_ek <= i_exponent_k;
            r_em <= i_base_n - 32'd1;
            r_en <= i_base_n;
            for (int i = 0; i < 4; i++) begin
                r_acc[i] <= t_res'(1);
            end
        end
        if (u.seq == SEQ_LOOP) begin
            r_ek <= r_ek >> 1;
            r_em <= r_em >> 1;
            r_en <= r_en >> 1;
        end
        if (wb_ctl.valid) begin
            case (wb_ctl.dst)
                DST_SQN:  r_sqn    <= wb_res;
                DST_SQM:  r_sqm    <= wb_res;
                DST_ACC0: r_acc[0] <= wb_res;
                DST_ACC1: r_acc[1] <= wb_res;
                DST_ACC2: r_acc[2] <= wb_res;
                DST_ACC3: r_acc[3] <= wb_res;
                default: ;
            endcase
        end
        unique case (u.post)
            POST_SUM:  r_sum <= sum_all;
            POST_RED4: r_sum <= red_val;
            POST_RED2: r_sum <= red_val;
            POST_RED1: r_out <= red_val[23:0];
            default: ;
        endcase
    end

    assign o_sum_mod = r_out;
    assign o_strobe  = r_strobe;

    `PSM_ASSERT_SAME(a_strobe_src, i_clk, i_rst_n, o_strobe, $past(r_pc) == UPC_RED1, "strobe without final fold step")
    `PSM_ASSERT_SAME(a_result_range, i_clk, i_rst_n, o_strobe, o_sum_mod < PSM_MOD, "result not reduced")
    `PSM_ASSERT_SAME(a_wb_in_flight, i_clk, i_rst_n, wb_ctl.valid, busy, "multiplier writeback while idle")
    `PSM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted transaction did not raise busy")

endmodule

// ----- src/psm_modmul.sv -----
// Pipelined modular multiplier: (a * b) mod 10000007 by Barrett reduction.
// Five register stages, correction on the output. Depends on psm_pkg.
module psm_modmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psm_pkg::t_mm_ctl  i_ctl,
    input  logic [31:0]       i_opa,
    input  psm_pkg::t_res     i_opb,
    output psm_pkg::t_mm_ctl  o_ctl,
    output psm_pkg::t_res     o_res
);
    import psm_pkg::*;

    localparam int STAGES = 5;

    t_mm_ctl     r_ctl [STAGES];
    logic [31:0] r_a;
    t_res        r_b;
    logic [47:0] r_p;
    t_res        r_q;
    t_sum        r_pl3;
    t_sum        r_pl4;
    t_sum        r_t;
    t_sum        r_r;

    logic [55:0] ab_full;
    logic [48:0] q_full;
    logic [47:0] t_full;
    t_sum        fix_res;

    assign ab_full = r_a * r_b;
    // P < 2^47, so P >> 23 fits 24 bits
    assign q_full  = r_p[46:23] * PSM_MU;
    assign t_full  = r_q * PSM_MOD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STAGES; i++) begin
                r_ctl[i] <= '{valid: 1'b0, dst: DST_NONE};
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int i = 1; i < STAGES; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= i_opa;
        r_b   <= i_opb;
        r_p   <= ab_full[47:0];
        r_q   <= q_full[48:25];
        r_pl3 <= r_p[25:0];
        r_t   <= t_full[25:0];
        r_pl4 <= r_pl3;
        // true remainder estimate is below 3M, exact mod 2^26
        r_r   <= r_pl4 - r_t;
    end

    always_comb begin
        priority if (r_r >= PSM_MOD_X2) begin
            fix_res = r_r - PSM_MOD_X2;
        end else if (r_r >= PSM_MOD_X1) begin
            fix_res = r_r - PSM_MOD_X1;
        end else begin
            fix_res = r_r;
        end
    end

    assign o_res = fix_res[23:0];
    assign o_ctl = r_ctl[STAGES-1];

endmodule

// ----- tb/sv/tb_power_sum_mod.sv -----
// Testbench for power_sum_mod: directed and random commands with self-checking results.
// Depends on psm_pkg and the power_sum_mod RTL only; the expected sums come from
// an in-bench square-and-multiply predictor held by a small scoreboard class.
`timescale 1ns / 100ps

module tb_power_sum_mod;

    import psm_pkg::*;

    localparam int          EXP_BITS      = 32;
    localparam bit [63:0]   SUM_MODULUS   = 64'd10000007;
    localparam int          RESULT_LATENCY = 6 * EXP_BITS + 16;
    localparam int          DRAIN_CYCLES   = RESULT_LATENCY + 32;
    // ~1500 commands in all; the limit allows ~5x the cycles they need
    localparam int          CYCLE_LIMIT    = 1_500_000;
    localparam int          RST_CYCLES     = 9;

    // ------------------------------------------------------------------
    // Scoreboard: predicts the weighted power sum for each accepted
    // command and checks results in order against the oldest prediction.
    // ------------------------------------------------------------------
    typedef struct {
        bit [31:0] base_n;
        bit [31:0] exponent_k;
        t_res      sum_mod;
    } t_sum_pred;

    class power_sum_ledger;
        t_sum_pred pending_sums[$];
        int        fail_count;

        function new();
            fail_count = 0;
        endfunction

        // right-to-left square-and-multiply, base reduced up front
        function bit [63:0] mod_power(bit [63:0] base, bit [31:0] expo);
            bit [63:0] acc;
            bit [63:0] sq;
            acc = 64'd1;
            sq  = base % SUM_MODULUS;
            for (int b = 0; b < EXP_BITS; b++) begin
                if (expo[b]) begin
                    acc = (acc * sq) % SUM_MODULUS;
                end
                sq = (sq * sq) % SUM_MODULUS;
            end
            return acc;
        endfunction

        function t_res weighted_power_sum(bit [31:0] n, bit [31:0] k);
            bit [31:0] n_less;
            bit [63:0] total;
            n_less = n - 32'd1;     // wraps to all ones for n = 0
            total  = mod_power({32'd0, n}, k)
                   + 64'd2 * mod_power({32'd0, n_less}, k)
                   + 64'd2 * mod_power({32'd0, n_less}, n_less)
                   + mod_power({32'd0, n}, n);
            total  = total % SUM_MODULUS;
            return total[23:0];
        endfunction

        function void note_command(bit [31:0] n, bit [31:0] k);
            t_sum_pred p;
            p.base_n     = n;
            p.exponent_k = k;
            p.sum_mod    = weighted_power_sum(n, k);
            pending_sums = {pending_sums, p};
        endfunction

        function void check_sum(t_res got);
            t_sum_pred p;
            if (pending_sums.size() == 0) begin
                $error("sum_mod: result %0d with no command outstanding", got);
                fail_count++;
                return;
            end
            p = pending_sums.pop_front();
            if (got !== p.sum_mod) begin
                $error("sum_mod: n=%0d k=%0d expected %0d, actual %0d",
                       p.base_n, p.exponent_k, p.sum_mod, got);
                fail_count++;
            end
        endfunction

        function int outstanding();
            return pending_sums.size();
        endfunction

        function bit clean();
            if (pending_sums.size() != 0) begin
                $error("sum_mod: %0d expected results never arrived",
                       pending_sums.size());
                fail_count++;
            end
            return fail_count == 0;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic [31:0] i_base_n     = '0;
    logic [31:0] i_exponent_k = '0;
    t_res        o_sum_mod;
    logic        o_strobe;

    power_sum_ledger ledger;
    int              idle_pct;      // chance in 100 that the sender sits out a cycle
    int              cycle_count = 0;

    power_sum_mod #(
        .EXP_BITS     (EXP_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_base_n     (i_base_n),
        .i_exponent_k (i_exponent_k),
        .o_sum_mod    (o_sum_mod),
        .o_strobe     (o_strobe)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop if the block hangs or drops a handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL power_sum_mod");
            $finish;
        end
    end

    // Result side: the receiver cannot stall, so every strobe cycle is a
    // transaction. Values read right after the edge are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            ledger.check_sum(o_sum_mod);
        end
    end

    // ------------------------------------------------------------------
    // Command side. One drive decision per cycle: either sit out (start
    // low, junk on the data lines) or present the command. The command is
    // taken at the first edge where start is high and busy is low. When
    // the next command follows without a gap, start simply stays high.
    // ------------------------------------------------------------------
    task automatic issue_command(input bit [31:0] n, input bit [31:0] k);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            if ($urandom_range(99) < idle_pct) begin
                start        <= 1'b0;
                i_base_n     <= $urandom;
                i_exponent_k <= $urandom;
            end else begin
                start        <= 1'b1;
                i_base_n     <= n;
                i_exponent_k <= k;
            end
            @(posedge i_clk);
            if (start && !busy) begin
                taken = 1'b1;
                ledger.note_command(n, k);
            end
        end
    endtask

    // Corners: zero exponents (0^0 = 1), base zero (n-1 wraps), n = 1 where
    // n-1 is zero, bases that reduce to zero or one modulo the constant,
    // all-ones fields and single-bit / alternating exponents.
    task automatic run_directed();
        bit [31:0] dir_n [22] = '{
            32'd1, 32'd1, 32'd1, 32'd2, 32'd2, 32'd2, 32'd3,
            32'd0, 32'd0, 32'd0,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
            32'd10000007, 32'd10000007, 32'd10000008, 32'd10000008,
            32'd20000014, 32'd10000006,
            32'h8000_0000, 32'h7FFF_FFFF, 32'd12345
        };
        bit [31:0] dir_k [22] = '{
            32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd10, 32'hFFFF_FFFF,
            32'd0, 32'd5, 32'hFFFF_FFFF,
            32'd0, 32'hFFFF_FFFF, 32'h8000_0000,
            32'd0, 32'd3, 32'd0, 32'd7,
            32'd1, 32'd2,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001
        };
        for (int i = 0; i < 22; i++) begin
            issue_command(dir_n[i], dir_k[i]);
        end
    endtask

    // Random mix: full-range fields in four draws of ten, plus small operands, bases near
    // multiples of the modulus, sparse exponents and bases near the top.
    task automatic run_random(input int count);
        bit [31:0] n;
        bit [31:0] k;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    n = $urandom;
                    k = $urandom;
                end
                4, 5: begin
                    n = $urandom_range(40, 1);
                    k = $urandom_range(40);
                end
                6: begin
                    n = 32'd10000007 * $urandom_range(429, 1) + $urandom_range(2);
                    k = $urandom_range(1) ? $urandom : $urandom_range(8);
                end
                7: begin
                    n = $urandom;
                    k = $urandom_range(1) ? (32'd1 << $urandom_range(31)) : 32'd0;
                end
                8: begin
                    n = $urandom;
                    k = 32'd0;
                end
                default: begin
                    n = 32'hFFFF_FFFF - $urandom_range(3);
                    k = $urandom;
                end
            endcase
            issue_command(n, k);
        end
    endtask

    initial begin
        ledger   = new();
        idle_pct = 8;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // light sender gaps, then heavy gaps, then back-to-back commands
        run_directed();
        run_random(478);
        idle_pct = 61;
        run_random(500);
        idle_pct = 0;
        run_random(500);
        start <= 1'b0;

        while (ledger.outstanding() != 0) @(posedge i_clk);
        // watch a while longer for stray strobes
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.clean()) begin
            $display("PASS power_sum_mod");
        end else begin
            $display("FAIL power_sum_mod");
        end
        $finish;
    end

endmodule
